// File: hdl/scd_pkg.sv
`default_nettype none
package scd_pkg;

    localparam int SIGNAL_COUNT = 64;

    localparam int KIND_W   = 3;
    localparam int SIG_W    = 6;
    localparam int STATUS_W = 2;
    localparam int MAP_W    = 64;
    localparam int GROUP_W  = 8;
    localparam int GROUP_N  = MAP_W / GROUP_W;
    localparam int GIDX_W   = 3;

    localparam logic [MAP_W-1:0] VALID_MASK = ~(MAP_W'(0)) >> (MAP_W - SIGNAL_COUNT);

    localparam logic [KIND_W-1:0] KIND_CLAIM    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_UNCLAIM  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SET      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DISPATCH = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_ACTIVE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CLAIM_SCAN,
        S_CLAIM_DONE,
        S_DISP_LOAD,
        S_DISP_SCAN,
        S_DISP_EMIT
    } fsm_state_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic scan;
        logic scan_dispatch;
        logic claim_commit;
        logic disp_load;
        logic disp_emit;
    } dp_cmd_t;

    typedef struct packed {
        logic disp_done;
    } dp_status_t;

endpackage
`default_nettype wire

// File: hdl/scd_datapath.sv
`default_nettype none
module scd_datapath (
    input  wire                         clk,
    input  wire                         rst_n,
    input  scd_pkg::dp_cmd_t            cmd,
    input  wire [scd_pkg::KIND_W-1:0]   kind,
    input  wire [scd_pkg::SIG_W-1:0]    signal_number,
    output scd_pkg::dp_status_t         stat,
    output logic                        result_valid,
    output logic [scd_pkg::SIG_W-1:0]   signal_out,
    output logic [scd_pkg::STATUS_W-1:0] status,
    output logic                        last
);
    import scd_pkg::*;

    logic [KIND_W-1:0]   kind_reg;
    logic [SIG_W-1:0]    num_reg;
    logic [MAP_W-1:0]    claimed_reg;
    logic [MAP_W-1:0]    claimed_next;
    logic [MAP_W-1:0]    pending_reg;
    logic [MAP_W-1:0]    pending_next;
    logic [MAP_W-1:0]    snap_reg;
    logic [MAP_W-1:0]    snap_next;
    logic [GROUP_N-1:0]  grp_any_reg;
    logic [GIDX_W-1:0]   grp_idx_reg [GROUP_N];
    logic [GROUP_N-1:0]  grp_any_next;
    logic [GIDX_W-1:0]   grp_idx_next [GROUP_N];

    logic                valid_reg;
    logic                valid_next;
    logic [SIG_W-1:0]    sig_reg;
    logic [SIG_W-1:0]    sig_next;
    logic [STATUS_W-1:0] stat_reg;
    logic [STATUS_W-1:0] stat_next;
    logic                last_reg;
    logic                last_next;

    logic [MAP_W-1:0]    scan_vec;
    logic                found;
    logic [GIDX_W-1:0]   sel_grp;
    logic [SIG_W-1:0]    pick_idx;
    logic [MAP_W-1:0]    pick_bit;
    logic [MAP_W-1:0]    rest;
    logic                rest_zero;
    logic [MAP_W-1:0]    num_bit;
    logic                in_range;

    // Each group of eight bits is encoded on its own; the results are registered.
    always_comb
    begin
        scan_vec = cmd.scan_dispatch ? snap_reg : (~claimed_reg & VALID_MASK);
        for (int g = 0; g < GROUP_N; g++)
        begin
            grp_any_next[g] = |scan_vec[g*GROUP_W +: GROUP_W];
            grp_idx_next[g] = '0;
            for (int b = GROUP_W - 1; b >= 0; b--)
            begin
                if (scan_vec[g*GROUP_W + b])
                begin
                    grp_idx_next[g] = GIDX_W'(b);
                end
            end
        end
    end

    always_comb
    begin
        found   = |grp_any_reg;
        sel_grp = '0;
        for (int g = GROUP_N - 1; g >= 0; g--)
        begin
            if (grp_any_reg[g])
            begin
                sel_grp = GIDX_W'(g);
            end
        end
        pick_idx  = {sel_grp, grp_idx_reg[sel_grp]};
        pick_bit  = MAP_W'(1) << pick_idx;
        rest      = snap_reg & ~pick_bit;
        rest_zero = (rest == '0);
        num_bit   = MAP_W'(1) << num_reg;
        in_range  = ({1'b0, num_reg} < (SIG_W + 1)'(SIGNAL_COUNT));
    end

    always_comb
    begin
        claimed_next = claimed_reg;
        pending_next = pending_reg;
        snap_next    = snap_reg;
        valid_next   = 1'b0;
        sig_next     = sig_reg;
        stat_next    = stat_reg;
        last_next    = last_reg;
        if (cmd.exec)
        begin
            if (in_range)
            begin
                case (kind_reg)
                    KIND_UNCLAIM: claimed_next = claimed_reg & ~num_bit;
                    KIND_SET:     pending_next = pending_reg | num_bit;
                    KIND_CLEAR:   pending_next = pending_reg & ~num_bit;
                    default:      ;
                endcase
            end
            valid_next = 1'b1;
            sig_next   = '0;
            stat_next  = STATUS_OK;
            last_next  = 1'b1;
        end
        if (cmd.claim_commit)
        begin
            valid_next = 1'b1;
            last_next  = 1'b1;
            if (found)
            begin
                claimed_next = claimed_reg | pick_bit;
                sig_next     = pick_idx;
                stat_next    = STATUS_OK;
            end
            else
            begin
                sig_next  = '0;
                stat_next = STATUS_NO_FREE;
            end
        end
        if (cmd.disp_load)
        begin
            snap_next    = pending_reg & claimed_reg & VALID_MASK;
            pending_next = '0;
        end
        if (cmd.disp_emit)
        begin
            valid_next = 1'b1;
            if (found)
            begin
                snap_next = rest;
                sig_next  = pick_idx;
                stat_next = STATUS_OK;
                last_next = rest_zero;
            end
            else
            begin
                sig_next  = '0;
                stat_next = STATUS_NO_ACTIVE;
                last_next = 1'b1;
            end
        end
    end

    assign stat.disp_done = !found || rest_zero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            claimed_reg <= '0;
            pending_reg <= '0;
            snap_reg    <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            claimed_reg <= claimed_next;
            pending_reg <= pending_next;
            snap_reg    <= snap_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sig_reg  <= sig_next;
        stat_reg <= stat_next;
        last_reg <= last_next;
        if (cmd.accept)
        begin
            kind_reg <= kind;
            num_reg  <= signal_number;
        end
        if (cmd.scan)
        begin
            grp_any_reg <= grp_any_next;
            for (int g = 0; g < GROUP_N; g++)
            begin
                grp_idx_reg[g] <= grp_idx_next[g];
            end
        end
    end

    assign result_valid = valid_reg;
    assign signal_out   = sig_reg;
    assign status       = stat_reg;
    assign last         = last_reg;

endmodule
`default_nettype wire

// File: hdl/scd_controller.sv
`default_nettype none
module scd_controller (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    input  wire [scd_pkg::KIND_W-1:0]   kind,
    input  scd_pkg::dp_status_t         stat,
    output scd_pkg::dp_cmd_t            cmd,
    output logic                        busy
);
    import scd_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (kind == KIND_CLAIM)
                    begin
                        state_next = S_CLAIM_SCAN;
                    end
                    else if (kind == KIND_DISPATCH)
                    begin
                        state_next = S_DISP_LOAD;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_IDLE;
            end
            S_CLAIM_SCAN:
            begin
                cmd.scan   = 1'b1;
                state_next = S_CLAIM_DONE;
            end
            S_CLAIM_DONE:
            begin
                cmd.claim_commit = 1'b1;
                state_next       = S_IDLE;
            end
            S_DISP_LOAD:
            begin
                cmd.disp_load = 1'b1;
                state_next    = S_DISP_SCAN;
            end
            S_DISP_SCAN:
            begin
                cmd.scan          = 1'b1;
                cmd.scan_dispatch = 1'b1;
                state_next        = S_DISP_EMIT;
            end
            S_DISP_EMIT:
            begin
                cmd.disp_emit = 1'b1;
                state_next    = stat.disp_done ? S_IDLE : S_DISP_SCAN;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: hdl/signal_claim_pending_dispatcher.sv
`default_nettype none
// Channel   Signals                               Handshake
// request   kind, signal_number                   taken when start & !busy
// result    signal_out, status, last              one cycle, result_valid strobe
//
// Each request is busy after acceptance while it executes (unclaim, set, clear and
// unknown kinds) or while it scans and commits (claim); its result is registered.
// Dispatch is busy for a load state, then a scan and an emit state per active signal
// (once if none is active); each search goes through a registered eight-by-eight encoder.
// Asynchronous reset clears the bitmaps and the controller.
// The receiver cannot stall: results are never held back.
module signal_claim_pending_dispatcher (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    output logic                        busy,
    input  wire [scd_pkg::KIND_W-1:0]   kind,
    input  wire [scd_pkg::SIG_W-1:0]    signal_number,
    output logic                        result_valid,
    output logic [scd_pkg::SIG_W-1:0]   signal_out,
    output logic [scd_pkg::STATUS_W-1:0] status,
    output logic                        last
);
    import scd_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t stat;

    scd_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    scd_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .kind          (kind),
        .signal_number (signal_number),
        .stat          (stat),
        .result_valid  (result_valid),
        .signal_out    (signal_out),
        .status        (status),
        .last          (last)
    );

endmodule
`default_nettype wire
